>>> rtl/scop_pkg.sv
// shared types, Q30 polynomial coefficients and the rounding multiply
// for the octant-polynomial sine/cosine pipeline; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package scop_pkg;

    // internal fixed point: Q30 values carried in 32-bit words
    localparam int QF = 30;
    localparam int QW = 32;

    localparam logic [QW-1:0] ONE_Q = QW'(1) << QF;

    // octants that evaluate the cosine polynomial
    localparam logic [7:0] OCT_COS_MASK = 8'h66;

    // full-precision coefficients, value times 2^30 rounded to nearest
    localparam logic [QW-1:0] COS_C2 = 32'd331168969;
    localparam logic [QW-1:0] COS_C4 = 32'd17023472;
    localparam logic [QW-1:0] COS_C6 = 32'd350030;
    localparam logic [QW-1:0] SIN_S1 = 32'd843314856;
    localparam logic [QW-1:0] SIN_S3 = 32'd86699833;
    localparam logic [QW-1:0] SIN_S5 = 32'd2673719;
    localparam logic [QW-1:0] SIN_S7 = 32'd39282;

    // low-order coefficients
    localparam logic [QW-1:0] FAST_C2 = 32'd331163453;
    localparam logic [QW-1:0] FAST_S1 = 32'd843306091;
    localparam logic [QW-1:0] FAST_S3 = 32'd86693915;

    // reduced angle handed from the front stage
    typedef struct packed {
        logic [QW-1:0] x;
        logic [2:0]    oct;
    } scop_red_t;

    // Q30 times Q30, round half up
    function automatic logic [QW-1:0] qmul(input logic [QW-1:0] a, input logic [QW-1:0] b);
        logic [2*QW-1:0] p;
        p = ({{QW{1'b0}}, a} * {{QW{1'b0}}, b}) + ((2*QW)'(1) << (QF - 1));
        return p[QF+QW-1:QF];
    endfunction

endpackage

`default_nettype wire

>>> rtl/sine_cosine_octant_poly.sv
// top level of the octant-polynomial sine/cosine generator: pipeline control,
// polynomial stages and output rounding; uses scop_pkg and scop_reduce
//
//  channel | signals                        | direction
//  --------+--------------------------------+----------
//  input   | in_valid, in_ready, phase,kind | request in
//  output  | out_valid, out_ready, amplitude| request out
//  config  | cfg_valid, cfg_ready, cfg_data | write in
//
// one request per clock sustained while out_ready is high; the depth is set by the chain of
// dependent 32x32 multiplies (x^2, x^4, then two more terms) each in its own stage.
// reset clears the stage valid bits and mode_reg to the full polynomial.
// every stage has its own enable, so a stall at the output fills bubbles first
// and input is still taken until the pipeline is full.
`timescale 1ns / 1ps
`default_nettype none

module sine_cosine_octant_poly
    import scop_pkg::*;
#(
    parameter int PHASE_BITS    = 32,
    parameter int OUT_FRAC_BITS = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [PHASE_BITS-1:0]         phase,
    input  wire logic                          kind,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [OUT_FRAC_BITS+1:0]    amplitude,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_data
);

    localparam int NS = 8;
    localparam int SH = QF - OUT_FRAC_BITS;
    localparam logic [QW:0] RND  = (SH > 0) ? ((QW+1)'(1) << (SH - 1)) : '0;
    localparam logic [QW:0] SATV = (QW+1)'(1) << OUT_FRAC_BITS;

    logic              mode_reg;
    logic [NS:1]       vld_reg;
    logic [NS:1]       vld_in;
    logic [NS+1:1]     adv;
    scop_red_t         red1;

    // stage 2..8 payload
    logic [QW-1:0]     x2_reg, sq2_reg;
    logic [2:0]        oct2_reg;
    logic [QW-1:0]     x3_reg, x4_3_reg, phi3_reg, plo3_reg;
    logic [2:0]        oct3_reg;
    logic [QW-1:0]     x4_reg, x4_4_reg, a4_reg, b4_reg;
    logic [2:0]        oct4_reg;
    logic [QW-1:0]     x5_reg, a5_reg, b5_reg, prod5_reg;
    logic [2:0]        oct5_reg;
    logic [QW-1:0]     x6_reg, t6_reg;
    logic [2:0]        oct6_reg;
    logic [QW-1:0]     r7_reg;
    logic [2:0]        oct7_reg;
    logic [OUT_FRAC_BITS+1:0] amp_reg;

    logic              cos3, cos4, cos7;
    logic [QW-1:0]     khi, klo, ka, kb;
    logic [QW:0]       rr;
    logic [QW:0]       mag;
    logic [OUT_FRAC_BITS+1:0] amp_next;

    // configuration register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            mode_reg <= cfg_data;
        end
    end

    // per-stage enables: a stage moves when it is empty or the next one moves
    always_comb
    begin
        adv[NS+1] = out_ready;
        for (int k = NS; k >= 1; k--)
        begin
            adv[k] = ~vld_reg[k] | adv[k+1];
        end
    end

    assign in_ready  = adv[1];
    assign out_valid = vld_reg[NS];
    assign vld_in    = {vld_reg[NS-1:1], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= NS; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    // stage 1: angle reduction
    scop_reduce #(
        .PHASE_BITS (PHASE_BITS)
    ) u_reduce (
        .clk   (clk),
        .en    (adv[1]),
        .phase (phase),
        .kind  (kind),
        .red   (red1)
    );

    // stage 2: x squared
    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            x2_reg   <= red1.x;
            sq2_reg  <= qmul(red1.x, red1.x);
            oct2_reg <= red1.oct;
        end
    end

    // stage 3: x^4 and the two products with x^2
    always_comb
    begin
        cos3 = OCT_COS_MASK[oct2_reg];
        if (mode_reg)
        begin
            khi = cos3 ? FAST_C2 : FAST_S3;
        end
        else
        begin
            khi = cos3 ? COS_C6 : SIN_S7;
        end
        klo = cos3 ? COS_C2 : SIN_S3;
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            x3_reg   <= x2_reg;
            x4_3_reg <= qmul(sq2_reg, sq2_reg);
            phi3_reg <= qmul(khi, sq2_reg);
            plo3_reg <= qmul(sq2_reg, klo);
            oct3_reg <= oct2_reg;
        end
    end

    // stage 4: subtract from the leading coefficients
    always_comb
    begin
        cos4 = OCT_COS_MASK[oct3_reg];
        ka   = cos4 ? ONE_Q : SIN_S1;
        if (mode_reg)
        begin
            kb = cos4 ? ONE_Q : FAST_S1;
        end
        else
        begin
            kb = cos4 ? COS_C4 : SIN_S5;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            x4_reg   <= x3_reg;
            x4_4_reg <= x4_3_reg;
            a4_reg   <= ka - plo3_reg;
            b4_reg   <= kb - phi3_reg;
            oct4_reg <= oct3_reg;
        end
    end

    // stage 5: x^4 term
    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            x5_reg    <= x4_reg;
            a5_reg    <= a4_reg;
            b5_reg    <= b4_reg;
            prod5_reg <= qmul(x4_4_reg, b4_reg);
            oct5_reg  <= oct4_reg;
        end
    end

    // stage 6: sum of terms, or the short form
    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            x6_reg   <= x5_reg;
            t6_reg   <= mode_reg ? b5_reg : a5_reg + prod5_reg;
            oct6_reg <= oct5_reg;
        end
    end

    // stage 7: final factor of x for the sine polynomial
    assign cos7 = OCT_COS_MASK[oct6_reg];

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            r7_reg   <= cos7 ? t6_reg : qmul(x6_reg, t6_reg);
            oct7_reg <= oct6_reg;
        end
    end

    // stage 8: round to output precision, cap at one, apply sign
    always_comb
    begin
        rr  = {1'b0, r7_reg} + RND;
        mag = rr >> SH;
        if (mag > SATV)
        begin
            mag = SATV;
        end
        amp_next = {1'b0, mag[OUT_FRAC_BITS:0]};
        if (oct7_reg[2])
        begin
            amp_next = -amp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            amp_reg <= amp_next;
        end
    end

    assign amplitude = signed'(amp_reg);

endmodule

`default_nettype wire

>>> rtl/scop_reduce.sv
// front stage: quarter-turn offset for cosine, octant split, mirroring
// and scaling of the fraction to Q30; uses scop_pkg
`timescale 1ns / 1ps
`default_nettype none

module scop_reduce
    import scop_pkg::*;
#(
    parameter int PHASE_BITS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [PHASE_BITS-1:0] phase,
    input  wire logic                  kind,
    output scop_red_t                  red
);

    localparam int FB = PHASE_BITS - 3;

    logic [PHASE_BITS-1:0] p_rot;
    logic [FB-1:0]         frac;
    logic [FB:0]           frac_m;
    logic [FB+QF:0]        frac_w;
    scop_red_t             red_next;
    scop_red_t             red_reg;

    // wrap-around add of a quarter turn, then mirror odd octants
    always_comb
    begin
        p_rot  = phase + (kind ? (PHASE_BITS'(1) << (PHASE_BITS - 2)) : '0);
        frac   = p_rot[FB-1:0];
        frac_m = p_rot[FB] ? ((FB+1)'(1) << FB) - {1'b0, frac} : {1'b0, frac};
        frac_w = {frac_m, {QF{1'b0}}};
        red_next.x   = QW'(frac_w[FB+QF:FB]);
        red_next.oct = p_rot[PHASE_BITS-1:PHASE_BITS-3];
    end

    // payload register, advanced by the stage enable
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg <= red_next;
        end
    end

    assign red = red_reg;

endmodule

`default_nettype wire
